// ===== design/gsd_pkg.sv =====
// Shared types and constants for the horizontal swipe gesture detector.
`timescale 1ns / 1ps

package gsd_pkg;

  localparam int unsigned HSUM_W = 18;
  localparam int unsigned VSUM_W = 17;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 1;

  typedef enum logic [IDX_W-1:0] {
    CFG_GESTURE_LENGTH = 1'b0,
    CFG_VERTICAL_TOL   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] gesture_length;
    logic [CFG_W-1:0] vertical_tolerance;
  } cfg_t;

  typedef struct packed {
    logic              drawing;
    logic [HSUM_W-1:0] hsum;
    logic [VSUM_W-1:0] vsum;
  } state_t;

endpackage

// ===== design/gsd_cfg.sv =====
// Configuration register file: gesture length and vertical tolerance.
`timescale 1ns / 1ps

module gsd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gsd_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [gsd_pkg::CFG_W-1:0]     cfg_data_i,
  output gsd_pkg::cfg_t                 cfg_o
);

  gsd_pkg::cfg_t    cfg_q, cfg_d;
  gsd_pkg::cfg_idx_e idx;

  assign idx = gsd_pkg::cfg_idx_e'(cfg_index_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (idx)
        gsd_pkg::CFG_GESTURE_LENGTH: cfg_d.gesture_length     = cfg_data_i;
        gsd_pkg::CFG_VERTICAL_TOL:   cfg_d.vertical_tolerance = cfg_data_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gesture_length     <= gsd_pkg::CFG_W'(100);
      cfg_q.vertical_tolerance <= gsd_pkg::CFG_W'(10);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/gsd_update.sv =====
// Per-packet state update and detection logic.
`timescale 1ns / 1ps

module gsd_update #(
  parameter int unsigned DELTA_WIDTH = 9
) (
  input  gsd_pkg::cfg_t           cfg_i,
  input  gsd_pkg::state_t         state_i,
  input  logic                    left_pressed_i,
  input  logic [DELTA_WIDTH-1:0]  move_x_i,
  input  logic [DELTA_WIDTH-1:0]  move_y_i,
  output gsd_pkg::state_t         state_o,
  output logic                    found_o
);

  localparam int unsigned HW = gsd_pkg::HSUM_W;
  localparam int unsigned VW = gsd_pkg::VSUM_W;
  localparam int unsigned CW = gsd_pkg::CFG_W;

  gsd_pkg::state_t  btn;
  logic             moved;
  logic [VW-1:0]    dy_ext;
  logic [VW-1:0]    ay;
  logic [VW:0]      vsum_wide;
  logic [VW-1:0]    vsum_new;
  logic [HW:0]      dx_ext;
  logic [HW:0]      hsum_wide;
  logic [HW-1:0]    hsum_new;
  logic [HW-1:0]    len_ext;
  logic             dir_ok;
  logic             tol_ok;
  logic             past_len;

  assign moved  = (move_x_i != '0) || (move_y_i != '0);
  assign dy_ext = {{(VW-DELTA_WIDTH){move_y_i[DELTA_WIDTH-1]}}, move_y_i};
  assign ay     = move_y_i[DELTA_WIDTH-1] ? (VW'(0) - dy_ext) : dy_ext;
  assign dx_ext = {{(HW+1-DELTA_WIDTH){move_x_i[DELTA_WIDTH-1]}}, move_x_i};
  assign len_ext = {{(HW-CW){cfg_i.gesture_length[CW-1]}}, cfg_i.gesture_length};

  always_comb begin
    // button first: release disarms and clears
    btn = state_i;
    if (left_pressed_i) begin
      btn.drawing = 1'b1;
    end else if (state_i.drawing) begin
      btn.drawing = 1'b0;
      btn.hsum    = '0;
      btn.vsum    = '0;
    end
  end

  always_comb begin
    vsum_wide = {1'b0, btn.vsum} + {1'b0, ay};
    vsum_new  = vsum_wide[VW] ? {VW{1'b1}} : vsum_wide[VW-1:0];
    hsum_wide = {btn.hsum[HW-1], btn.hsum} + dx_ext;
    // overflow when the two top bits disagree
    if (hsum_wide[HW] != hsum_wide[HW-1]) begin
      hsum_new = hsum_wide[HW] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}};
    end else begin
      hsum_new = hsum_wide[HW-1:0];
    end
    dir_ok = (move_x_i[DELTA_WIDTH-1] == cfg_i.gesture_length[CW-1]);
    tol_ok = (vsum_new <= {1'b0, cfg_i.vertical_tolerance});
    past_len = (hsum_new[HW-1] == cfg_i.gesture_length[CW-1]) &&
               (hsum_new[HW-1] ? ($signed(hsum_new) < $signed(len_ext))
                               : ($signed(hsum_new) > $signed(len_ext)));
  end

  always_comb begin
    state_o = btn;
    found_o = 1'b0;
    if (btn.drawing && moved) begin
      if (dir_ok && tol_ok) begin
        state_o.vsum = vsum_new;
        state_o.hsum = hsum_new;
        found_o      = past_len;
      end else begin
        state_o.vsum = '0;
        state_o.hsum = '0;
      end
    end
  end

endmodule

// ===== design/horizontal_swipe_gesture_detector_core.sv =====
// Top level of the horizontal swipe gesture detector.
//
//   channel   handshake                    payload
//   in        in_valid_i / in_stall_o      left_pressed_i, move_x_i, move_y_i
//   out       out_valid_o / out_stall_i    gesture_found_o
//   cfg       cfg_we_i                     cfg_index_i, cfg_data_i
//
// One item per cycle while out_stall_i is low; items pass through the input register, then the result register.
// The gesture state updates in the same cycle an item moves from the input register
// to the result register, through one pass of the update logic.
// Reset clears the gesture state, both pipeline valids and loads the register defaults.
// A stalled result holds the input register; input stalls only when both are full.
`timescale 1ns / 1ps

module horizontal_swipe_gesture_detector_core #(
  parameter int unsigned DELTA_WIDTH = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          left_pressed_i,
  input  logic signed [DELTA_WIDTH-1:0] move_x_i,
  input  logic signed [DELTA_WIDTH-1:0] move_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          gesture_found_o,
  input  logic                          cfg_we_i,
  input  logic [gsd_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [gsd_pkg::CFG_W-1:0]     cfg_data_i
);

  gsd_pkg::cfg_t   cfg;
  gsd_pkg::state_t state_q, state_d;

  logic                   in_valid_q, in_valid_d;
  logic                   left_q;
  logic [DELTA_WIDTH-1:0] mx_q, my_q;
  logic                   out_valid_q, out_valid_d;
  logic                   found_q, found_d;
  logic                   out_ready;
  logic                   adv;
  logic                   in_acc;

  gsd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gsd_update #(
    .DELTA_WIDTH (DELTA_WIDTH)
  ) u_update (
    .cfg_i          (cfg),
    .state_i        (state_q),
    .left_pressed_i (left_q),
    .move_x_i       (mx_q),
    .move_y_i       (my_q),
    .state_o        (state_d),
    .found_o        (found_d)
  );

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_acc) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      left_q <= left_pressed_i;
      mx_q   <= move_x_i;
      my_q   <= move_y_i;
    end
    if (adv) begin
      found_q <= found_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign gesture_found_o = found_q;

`ifndef ASSERT_OFF
  // release while drawing leaves an empty, disarmed state
  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !left_q) |=> (!state_q.drawing && state_q.hsum == '0 && state_q.vsum == '0))
    else $error("release did not clear gesture state");

  // a reported gesture only comes from an armed state
  a_found_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && found_q) |-> state_q.drawing)
    else $error("gesture reported while not drawing");

  // an item leaving the input register always lands in the result register
  a_adv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("advanced item lost");

  // the gesture state moves only when an item advances
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(state_q))
    else $error("gesture state changed without an item");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the horizontal swipe gesture detector core.
`timescale 1ns / 1ps

module tb;

  localparam int DELTA_W     = 9;
  localparam int CLK_PERIOD  = 4;
  localparam int DRAIN       = 4;
  localparam int STUCK_LIMIT = 3000;
  localparam int HSUM_HI     = 131071;
  localparam int HSUM_LO     = -131072;
  localparam int VSUM_HI     = 131071;
  localparam int LONG_DRAG   = 525;

  typedef struct {
    bit                        pressed;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
  } packet_t;

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_stall_o;
  logic                          left_pressed_i = 1'b0;
  logic signed [DELTA_W-1:0]     move_x_i       = '0;
  logic signed [DELTA_W-1:0]     move_y_i       = '0;
  logic                          out_valid_o;
  logic                          out_stall_i    = 1'b0;
  logic                          gesture_found_o;
  logic                          cfg_we_i       = 1'b0;
  logic [gsd_pkg::IDX_W-1:0]     cfg_index_i    = gsd_pkg::CFG_GESTURE_LENGTH;
  logic [gsd_pkg::CFG_W-1:0]     cfg_data_i     = '0;

  horizontal_swipe_gesture_detector_core #(
    .DELTA_WIDTH(DELTA_W)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .left_pressed_i (left_pressed_i),
    .move_x_i       (move_x_i),
    .move_y_i       (move_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .gesture_found_o(gesture_found_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Predictor copy of registers and gesture state
  logic signed [gsd_pkg::CFG_W-1:0] len_cfg  = 16'sd100;
  logic [gsd_pkg::CFG_W-1:0]        vtol_cfg = 16'd10;
  bit                               drawing_q;
  int                               hsum_q;
  int                               vsum_q;

  packet_t packet_q[$];
  bit      found_pred_q[$];

  int  sender_idle_pct;
  int  recv_idle_pct;
  bit  hold_sender;
  int  n_queued;
  int  n_accepted;
  int  n_results;
  int  n_found;
  int  n_writes;
  int  n_errors;
  int  stuck_cycles;

  function automatic bit predict_gesture(bit pressed, logic signed [DELTA_W-1:0] dx,
                                         logic signed [DELTA_W-1:0] dy);
    int sx, sy, lenv, tol, h, ah, al;
    bit found;
    sx    = dx;
    sy    = dy;
    lenv  = len_cfg;
    tol   = vtol_cfg;
    found = 1'b0;
    if (pressed) begin
      drawing_q = 1'b1;
    end else if (drawing_q) begin
      drawing_q = 1'b0;
      hsum_q    = 0;
      vsum_q    = 0;
    end
    if (drawing_q && (sx != 0 || sy != 0)) begin
      vsum_q = vsum_q + ((sy < 0) ? -sy : sy);
      if (vsum_q > VSUM_HI) vsum_q = VSUM_HI;
      // zero counts as a positive direction
      if (((sx < 0) == (lenv < 0)) && vsum_q <= tol) begin
        h = hsum_q + sx;
        if (h > HSUM_HI) h = HSUM_HI;
        if (h < HSUM_LO) h = HSUM_LO;
        hsum_q = h;
        ah     = (h < 0) ? -h : h;
        al     = (lenv < 0) ? -lenv : lenv;
        found  = (ah > al) && ((h < 0) == (lenv < 0));
      end else begin
        hsum_q = 0;
        vsum_q = 0;
      end
    end
    return found;
  endfunction

  function automatic void add_packet(bit pressed, int dx, int dy);
    packet_t pk;
    pk.pressed = pressed;
    pk.dx      = dx[DELTA_W-1:0];
    pk.dy      = dy[DELTA_W-1:0];
    packet_q.push_back(pk);
    n_queued++;
  endfunction

  function automatic int signed_rand(int m);
    int v;
    v = $urandom_range(m);
    return ($urandom_range(1) == 1) ? -v : v;
  endfunction

  function automatic void queue_noise();
    add_packet($urandom_range(1), int'($urandom_range(511)) - 256,
               int'($urandom_range(511)) - 256);
  endfunction

  // Press, a run of drag packets with occasional disturbances, then usually a release
  function automatic void queue_swipe(int max_step, int max_dy);
    int dir, steps, r, mag;
    dir   = (len_cfg < 0) ? -1 : 1;
    steps = $urandom_range(12, 1);
    mag   = $urandom_range(max_step);
    add_packet(1'b1, dir * mag, signed_rand(max_dy));
    for (int i = 0; i < steps; i++) begin
      r   = $urandom_range(99);
      mag = $urandom_range(max_step);
      if (r < 8)       add_packet(1'b1, -dir * mag, signed_rand(max_dy));
      else if (r < 14) add_packet(1'b1, 0, 0);
      else if (r < 20) add_packet(1'b1, dir * mag, signed_rand(255));
      else             add_packet(1'b1, dir * mag, signed_rand(max_dy));
    end
    if ($urandom_range(99) < 85)
      add_packet(1'b0, int'($urandom_range(511)) - 256, int'($urandom_range(511)) - 256);
  endfunction

  function automatic void fill_random(int count, int max_step, int max_dy);
    int goal;
    goal = n_queued + count;
    while (n_queued < goal) begin
      if ($urandom_range(99) < 80) queue_swipe(max_step, max_dy);
      else queue_noise();
    end
  endfunction

  function automatic void note_error(string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  task automatic settle();
    while (packet_q.size() != 0 || in_valid_i || found_pred_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(gsd_pkg::cfg_idx_e idx, logic [gsd_pkg::CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gsd_pkg::CFG_GESTURE_LENGTH) len_cfg = value;
    else vtol_cfg = value;
    n_writes++;
  endtask

  task automatic set_regs(logic [gsd_pkg::CFG_W-1:0] length,
                          logic [gsd_pkg::CFG_W-1:0] tol);
    settle();
    write_reg(gsd_pkg::CFG_GESTURE_LENGTH, length);
    write_reg(gsd_pkg::CFG_VERTICAL_TOL, tol);
  endtask

  // Driver: an item stays on the port until it is taken
  always @(posedge clk_i) begin
    packet_t pk;
    bit      go;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        found_pred_q.push_back(predict_gesture(left_pressed_i, move_x_i, move_y_i));
        n_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        go = !hold_sender && packet_q.size() != 0 &&
             ($urandom_range(99) >= sender_idle_pct);
        if (go) begin
          pk             = packet_q.pop_front();
          in_valid_i     <= 1'b1;
          left_pressed_i <= pk.pressed;
          move_x_i       <= pk.dx;
          move_y_i       <= pk.dy;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    bit want;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (gesture_found_o === 1'b1) n_found++;
        if (found_pred_q.size() == 0) begin
          note_error($sformatf("result %0b with nothing outstanding", gesture_found_o));
        end else begin
          want = found_pred_q.pop_front();
          if (gesture_found_o !== want)
            note_error($sformatf("result %0d: gesture_found expected %0b, got %0b",
                                 n_results, want, gesture_found_o));
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STUCK_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    int mag;
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    hold_sender     = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: length 100, tolerance 10
    add_packet(1'b0, 255, -256);   // release while idle
    add_packet(1'b1, 0, 0);        // press, no movement
    add_packet(1'b1, 60, 3);
    add_packet(1'b1, 41, 0);       // passes the length
    add_packet(1'b1, 0, 0);        // held, no movement, no report
    add_packet(1'b1, 1, 7);        // vertical sum right at tolerance
    add_packet(1'b1, 1, 1);        // over tolerance clears
    add_packet(1'b1, -5, 0);       // wrong direction clears
    add_packet(1'b1, 100, 0);      // equal to length is not enough
    add_packet(1'b1, 0, -10);      // zero x counts as positive
    add_packet(1'b1, 1, 0);
    add_packet(1'b0, -256, 255);   // release ignores movement
    add_packet(1'b0, 50, 0);
    set_regs(16'hFFFF, 16'd0);     // length -1, zero tolerance
    add_packet(1'b1, -1, 0);
    add_packet(1'b1, -256, 0);
    add_packet(1'b1, 0, 0);
    add_packet(1'b1, -3, 1);
    add_packet(1'b0, 0, 0);
    set_regs(16'd0, 16'hFFFF);     // length zero, widest tolerance
    add_packet(1'b1, 0, -256);
    add_packet(1'b1, 1, 255);
    add_packet(1'b1, -1, 0);
    add_packet(1'b0, 0, 0);

    // Sender idles lightly, receiver heavily; sender pauses until drained midway
    set_regs(16'd100, 16'd10);
    sender_idle_pct = 20;
    recv_idle_pct   = 47;
    fill_random(120, 60, 4);
    while (packet_q.size() > 60) @(posedge clk_i);
    hold_sender = 1'b1;
    while (found_pred_q.size() != 0 || in_valid_i) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    hold_sender = 1'b0;

    set_regs(16'(-300), 16'd200);
    sender_idle_pct = 47;
    recv_idle_pct   = 20;
    fill_random(100, 120, 30);

    set_regs(16'd0, 16'd0);
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    fill_random(60, 255, 2);

    // Long drags reach the largest lengths and push the sum into saturation
    set_regs(16'sd32767, 16'hFFFF);
    add_packet(1'b1, 0, 0);
    for (int i = 0; i < LONG_DRAG; i++) begin
      mag = $urandom_range(255, 250);
      add_packet(1'b1, mag, signed_rand(120));
    end
    add_packet(1'b0, 0, 0);
    set_regs(16'h8000, 16'hFFFF);
    add_packet(1'b1, 0, 0);
    for (int i = 0; i < LONG_DRAG; i++) begin
      mag = $urandom_range(256, 251);
      add_packet(1'b1, -mag, signed_rand(120));
    end
    add_packet(1'b0, 0, 0);
    settle();

    if (found_pred_q.size() != 0)
      note_error($sformatf("%0d results never arrived", found_pred_q.size()));
    $display("Sent %0d packets over %0d register writes, lengths from -32768 to 32767.",
             n_accepted, n_writes);
    $display("Checked %0d results, %0d gestures found, %0d errors.",
             n_results, n_found, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
